### rtl/core/tee_pkg.sv
// shared types, constants and event codes of the touch event encoder
package tee_pkg;

   localparam int TRACK_ID_WIDTH = 16;
   localparam int COORD_WIDTH = 16;
   localparam int VALUE_WIDTH = 17;
   localparam int CODE_WIDTH = 9;
   localparam int TYPE_WIDTH = 2;
   localparam int KIND_WIDTH = 2;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 16;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_WIDTH = $clog2(QUEUE_DEPTH + 3);

   localparam logic [COORD_WIDTH-1:0] FULL_SCALE = '1;

   localparam logic [KIND_WIDTH-1:0] KIND_DOWN = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_UP = 2'd1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_X_MIN = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_X_MAX = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_Y_MIN = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_Y_MAX = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MULTI_MODE = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROTATE_AXES = 3'd5;

   localparam logic [TYPE_WIDTH-1:0] EVT_SYN = 2'd0;
   localparam logic [TYPE_WIDTH-1:0] EVT_KEY = 2'd1;
   localparam logic [TYPE_WIDTH-1:0] EVT_ABS = 2'd3;

   localparam logic [CODE_WIDTH-1:0] CODE_ABS_X = 9'd0;
   localparam logic [CODE_WIDTH-1:0] CODE_ABS_Y = 9'd1;
   localparam logic [CODE_WIDTH-1:0] CODE_MT_X = 9'd53;
   localparam logic [CODE_WIDTH-1:0] CODE_MT_Y = 9'd54;
   localparam logic [CODE_WIDTH-1:0] CODE_MT_TRACK = 9'd57;
   localparam logic [CODE_WIDTH-1:0] CODE_MT_PRESS = 9'd58;
   localparam logic [CODE_WIDTH-1:0] CODE_BTN_TOUCH = 9'd330;
   localparam logic [CODE_WIDTH-1:0] CODE_SYN_REPORT = 9'd0;

   localparam logic [VALUE_WIDTH-1:0] VALUE_RELEASE_ID = '1;
   localparam logic [VALUE_WIDTH-1:0] VALUE_PRESSURE = 17'd100;
   localparam logic [VALUE_WIDTH-1:0] VALUE_ZERO = '0;
   localparam logic [VALUE_WIDTH-1:0] VALUE_ONE = 17'd1;

   // one bit per event of a sequence, emitted lowest bit first
   localparam int NUM_STEPS = 9;
   localparam logic [NUM_STEPS-1:0] STEP_NONE = 9'b000000000;
   localparam logic [NUM_STEPS-1:0] STEP_REL_TRACK = 9'b000000001;
   localparam logic [NUM_STEPS-1:0] STEP_REL_KEY = 9'b000000010;
   localparam logic [NUM_STEPS-1:0] STEP_REL_SYN = 9'b000000100;
   localparam logic [NUM_STEPS-1:0] STEP_PR_TRACK = 9'b000001000;
   localparam logic [NUM_STEPS-1:0] STEP_PR_KEY = 9'b000010000;
   localparam logic [NUM_STEPS-1:0] STEP_MV_X = 9'b000100000;
   localparam logic [NUM_STEPS-1:0] STEP_MV_Y = 9'b001000000;
   localparam logic [NUM_STEPS-1:0] STEP_MV_PRESS = 9'b010000000;
   localparam logic [NUM_STEPS-1:0] STEP_MV_SYN = 9'b100000000;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x_min;
      logic signed [COORD_WIDTH-1:0] x_max;
      logic signed [COORD_WIDTH-1:0] y_min;
      logic signed [COORD_WIDTH-1:0] y_max;
      logic                          multi_mode;
      logic                          rotate_axes;
   } tee_cfg_type;

   typedef struct packed {
      logic [NUM_STEPS-1:0]          steps;
      logic                          multi;
      logic signed [VALUE_WIDTH-1:0] pos_x;
      logic signed [VALUE_WIDTH-1:0] pos_y;
      logic [TRACK_ID_WIDTH-1:0]     track_id;
   } tee_cmd_type;

endpackage

### rtl/core/touch_event_encoder.sv
// touch event encoder top level: register file and the front, queue and sequencer
//
// usage
//   req channel: one touch command per transfer, normalized x and y in req_tdata,
//   kind, mirror and flip in req_tuser
//   rsp channel: the evdev events of each command in order, one per transfer,
//   rsp_tlast on the final event of a command
//   csr port: registers written with csr_we high; user writes only while idle, unchecked
// path: the first scaling stage loads at the command's transfer; the second stage,
//   queue write, sequencer load and output register follow in that order, and the
//   output register raises rsp_tvalid
// throughput: the sequencer emits one event per cycle while rsp_tready is high;
//   a command has 2 to 9 events, and the single event sequencer loads the next
//   command only after emitting the last event of the current one; the front takes
//   a command every cycle while the four-entry command queue has room
// reset: touch released, tracking id 0, all ranges and modes 0, queue empty
// stall: when rsp_tready is low the output register holds its event, the
//   sequencer waits, the queue fills and req_tready drops once it is booked full
module touch_event_encoder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [63:0]                          req_tdata,  // norm_x, norm_y
   input  logic [3:0]                           req_tuser,  // touch_kind, mirror, flip
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [31:0]                          rsp_tdata,  // event_code, event_value, pad
   output logic [tee_pkg::TYPE_WIDTH-1:0]       rsp_tuser,  // event_type
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [tee_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [tee_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import tee_pkg::*;

   tee_cfg_type             cfg_ff;
   logic                    push;
   tee_cmd_type             push_cmd;
   logic                    pop;
   tee_cmd_type             pop_cmd;
   logic                    q_empty;
   logic [QCOUNT_WIDTH-1:0] q_count;
   logic [CODE_WIDTH-1:0]   event_code;
   logic [VALUE_WIDTH-1:0]  event_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_X_MIN: cfg_ff.x_min <= csr_wdata;
            CSR_X_MAX: cfg_ff.x_max <= csr_wdata;
            CSR_Y_MIN: cfg_ff.y_min <= csr_wdata;
            CSR_Y_MAX: cfg_ff.y_max <= csr_wdata;
            CSR_MULTI_MODE: cfg_ff.multi_mode <= csr_wdata[0];
            CSR_ROTATE_AXES: cfg_ff.rotate_axes <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   tee_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .norm_x     (req_tdata[31:0]),
      .norm_y     (req_tdata[63:32]),
      .touch_kind (req_tuser[1:0]),
      .mirror     (req_tuser[2]),
      .flip       (req_tuser[3]),
      .q_count    (q_count),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   tee_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .empty    (q_empty),
      .count    (q_count)
   );

   tee_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_cmd       (pop_cmd),
      .q_empty     (q_empty),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .event_type  (rsp_tuser),
      .event_code  (event_code),
      .event_value (event_value),
      .last_event  (rsp_tlast)
   );

   assign rsp_tdata = {6'd0, event_value, event_code};

endmodule

### rtl/core/tee_front.sv
// front end: accepts touch commands, plans the event sequence and scales coordinates
module tee_front (
   input  logic                            clock,
   input  logic                            reset,
   input  tee_pkg::tee_cfg_type            cfg,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [31:0]                     norm_x,
   input  logic [31:0]                     norm_y,
   input  logic [tee_pkg::KIND_WIDTH-1:0]  touch_kind,
   input  logic                            mirror,
   input  logic                            flip,
   input  logic [tee_pkg::QCOUNT_WIDTH-1:0] q_count,
   output logic                            push,
   output tee_pkg::tee_cmd_type            push_cmd
);
   import tee_pkg::*;

   function automatic logic [COORD_WIDTH-1:0] div_full_scale(input logic [31:0] p);
      logic [COORD_WIDTH-1:0] hi;
      logic [COORD_WIDTH:0]   s;
      logic [1:0]             extra;
      hi = p[31:16];
      s = {1'b0, hi} + {1'b0, p[15:0]};
      if (s >= {FULL_SCALE, 1'b0}) begin
         extra = 2'd2;
      end else if (s >= {1'b0, FULL_SCALE}) begin
         extra = 2'd1;
      end else begin
         extra = 2'd0;
      end
      return hi + COORD_WIDTH'(extra);
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] place(input logic signed [COORD_WIDTH-1:0] base,
                                                    input logic [COORD_WIDTH-1:0] q,
                                                    input logic neg);
      logic [VALUE_WIDTH-1:0] b;
      logic [VALUE_WIDTH-1:0] qq;
      b = {base[COORD_WIDTH-1], base};
      qq = {1'b0, q};
      return neg ? b - qq : b + qq;
   endfunction

   logic                          accept;
   logic [QCOUNT_WIDTH-1:0]       occupancy;
   logic                          swap;
   logic [COORD_WIDTH-1:0]        sat_x, sat_y, cx, cy;
   logic [VALUE_WIDTH-1:0]        span_x, span_y;
   logic [NUM_STEPS-1:0]          rel_steps, mv_steps, steps;

   logic                          released_ff, released_in;
   logic [TRACK_ID_WIDTH-1:0]     track_ff, track_in;

   logic                          s1_valid_ff;
   logic [COORD_WIDTH-1:0]        s1_coord_h_ff, s1_coord_v_ff;
   logic [COORD_WIDTH-1:0]        s1_mag_h_ff, s1_mag_v_ff;
   logic                          s1_neg_h_ff, s1_neg_v_ff;
   logic signed [COORD_WIDTH-1:0] s1_base_h_ff, s1_base_v_ff;
   logic [NUM_STEPS-1:0]          s1_steps_ff;
   logic                          s1_multi_ff;
   logic [TRACK_ID_WIDTH-1:0]     s1_track_ff;

   logic                          s2_valid_ff;
   logic [31:0]                   s2_prod_h_ff, s2_prod_v_ff;
   logic                          s2_neg_h_ff, s2_neg_v_ff;
   logic signed [COORD_WIDTH-1:0] s2_base_h_ff, s2_base_v_ff;
   logic [NUM_STEPS-1:0]          s2_steps_ff;
   logic                          s2_multi_ff;
   logic [TRACK_ID_WIDTH-1:0]     s2_track_ff;

   // credit check covers items already inside the scaling stages
   assign occupancy = q_count + QCOUNT_WIDTH'(s1_valid_ff) + QCOUNT_WIDTH'(s2_valid_ff);
   assign in_ready = occupancy < QCOUNT_WIDTH'(QUEUE_DEPTH);
   assign accept = in_valid && in_ready;

   always_comb begin
      sat_x = (|norm_x[31:COORD_WIDTH]) ? FULL_SCALE : norm_x[COORD_WIDTH-1:0];
      sat_y = (|norm_y[31:COORD_WIDTH]) ? FULL_SCALE : norm_y[COORD_WIDTH-1:0];
      cx = mirror ? ~sat_x : sat_x;
      cy = mirror ? ~sat_y : sat_y;
      swap = cfg.rotate_axes || flip;
      span_x = {cfg.x_max[COORD_WIDTH-1], cfg.x_max} - {cfg.x_min[COORD_WIDTH-1], cfg.x_min};
      span_y = {cfg.y_max[COORD_WIDTH-1], cfg.y_max} - {cfg.y_min[COORD_WIDTH-1], cfg.y_min};
   end

   always_comb begin
      rel_steps = STEP_REL_KEY | STEP_REL_SYN | (cfg.multi_mode ? STEP_REL_TRACK : STEP_NONE);
      mv_steps = STEP_MV_X | STEP_MV_Y | STEP_MV_SYN
                 | (cfg.multi_mode ? STEP_MV_PRESS : STEP_NONE);
      released_in = released_ff;
      track_in = track_ff;
      case (touch_kind)
         KIND_UP: begin
            steps = rel_steps;
            released_in = 1'b1;
         end
         KIND_DOWN: begin
            steps = (released_ff ? STEP_NONE : rel_steps) | STEP_PR_KEY | mv_steps
                    | (cfg.multi_mode ? STEP_PR_TRACK : STEP_NONE);
            released_in = 1'b0;
            if (cfg.multi_mode) begin
               track_in = track_ff + TRACK_ID_WIDTH'(1);
            end
         end
         default: begin
            steps = mv_steps;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         released_ff <= 1'b1;
         track_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            released_ff <= released_in;
            track_ff <= track_in;
         end
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // stage 1: operands of both scalings
   always_ff @(posedge clock) begin
      s1_coord_h_ff <= swap ? cy : cx;
      s1_coord_v_ff <= swap ? cx : cy;
      s1_mag_h_ff <= span_x[VALUE_WIDTH-1] ? COORD_WIDTH'(-span_x) : span_x[COORD_WIDTH-1:0];
      s1_mag_v_ff <= span_y[VALUE_WIDTH-1] ? COORD_WIDTH'(-span_y) : span_y[COORD_WIDTH-1:0];
      s1_neg_h_ff <= span_x[VALUE_WIDTH-1] ^ swap;
      s1_neg_v_ff <= span_y[VALUE_WIDTH-1];
      s1_base_h_ff <= swap ? cfg.x_max : cfg.x_min;
      s1_base_v_ff <= cfg.y_min;
      s1_steps_ff <= steps;
      s1_multi_ff <= cfg.multi_mode;
      s1_track_ff <= track_ff;
   end

   // stage 2: products
   always_ff @(posedge clock) begin
      s2_prod_h_ff <= s1_coord_h_ff * s1_mag_h_ff;
      s2_prod_v_ff <= s1_coord_v_ff * s1_mag_v_ff;
      s2_neg_h_ff <= s1_neg_h_ff;
      s2_neg_v_ff <= s1_neg_v_ff;
      s2_base_h_ff <= s1_base_h_ff;
      s2_base_v_ff <= s1_base_v_ff;
      s2_steps_ff <= s1_steps_ff;
      s2_multi_ff <= s1_multi_ff;
      s2_track_ff <= s1_track_ff;
   end

   // stage 3: divide by full scale and offset, straight into the queue
   assign push = s2_valid_ff;
   always_comb begin
      push_cmd.steps = s2_steps_ff;
      push_cmd.multi = s2_multi_ff;
      push_cmd.pos_x = place(s2_base_h_ff, div_full_scale(s2_prod_h_ff), s2_neg_h_ff);
      push_cmd.pos_y = place(s2_base_v_ff, div_full_scale(s2_prod_v_ff), s2_neg_v_ff);
      push_cmd.track_id = s2_track_ff;
   end

   ap_no_overbook: assert property (@(posedge clock) disable iff (reset)
      occupancy <= QCOUNT_WIDTH'(QUEUE_DEPTH))
      else $error("front books more items than the queue holds");

   ap_track_step: assert property (@(posedge clock) disable iff (reset)
      (accept && touch_kind == KIND_DOWN && cfg.multi_mode)
      |=> track_ff == $past(track_ff) + TRACK_ID_WIDTH'(1))
      else $error("tracking id did not advance on press");

   ap_press_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && touch_kind == KIND_DOWN) |=> !released_ff)
      else $error("press left the touch released");

endmodule

### rtl/core/tee_queue.sv
// command queue between the front end and the event sequencer
module tee_queue (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  tee_pkg::tee_cmd_type             push_cmd,
   input  logic                             pop,
   output tee_pkg::tee_cmd_type             pop_cmd,
   output logic                             empty,
   output logic [tee_pkg::QCOUNT_WIDTH-1:0] count
);
   import tee_pkg::*;

   tee_cmd_type             entries_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCOUNT_WIDTH-1:0] count_ff;

   assign pop_cmd = entries_ff[rd_ptr_ff];
   assign empty = count_ff == '0;
   assign count = count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_WIDTH'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_WIDTH'(1);
         end
         count_ff <= count_ff + QCOUNT_WIDTH'(push) - QCOUNT_WIDTH'(pop);
      end
   end

   ap_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");

endmodule

### rtl/core/tee_back.sv
// event sequencer: walks the planned steps of each command onto the result channel
module tee_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tee_pkg::tee_cmd_type                  q_cmd,
   input  logic                                  q_empty,
   output logic                                  pop,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic [tee_pkg::TYPE_WIDTH-1:0]        event_type,
   output logic [tee_pkg::CODE_WIDTH-1:0]        event_code,
   output logic [tee_pkg::VALUE_WIDTH-1:0]       event_value,
   output logic                                  last_event
);
   import tee_pkg::*;

   tee_cmd_type            cur_ff;
   logic                   have;
   logic                   out_free;
   logic                   emit;
   logic [NUM_STEPS-1:0]   sel;
   logic [NUM_STEPS-1:0]   rest;
   logic [TYPE_WIDTH-1:0]  ev_type;
   logic [CODE_WIDTH-1:0]  ev_code;
   logic [VALUE_WIDTH-1:0] ev_value;

   logic                   out_valid_ff;
   logic [TYPE_WIDTH-1:0]  out_type_ff;
   logic [CODE_WIDTH-1:0]  out_code_ff;
   logic [VALUE_WIDTH-1:0] out_value_ff;
   logic                   out_last_ff;

   assign have = |cur_ff.steps;
   assign out_free = !out_valid_ff || out_ready;
   assign emit = have && out_free;
   assign pop = !have && !q_empty;
   assign sel = cur_ff.steps & (~cur_ff.steps + NUM_STEPS'(1));
   assign rest = cur_ff.steps & ~sel;

   always_comb begin
      case (sel)
         STEP_REL_TRACK: begin
            ev_type = EVT_ABS;
            ev_code = CODE_MT_TRACK;
            ev_value = VALUE_RELEASE_ID;
         end
         STEP_REL_KEY: begin
            ev_type = EVT_KEY;
            ev_code = CODE_BTN_TOUCH;
            ev_value = VALUE_ZERO;
         end
         STEP_PR_TRACK: begin
            ev_type = EVT_ABS;
            ev_code = CODE_MT_TRACK;
            ev_value = VALUE_WIDTH'(cur_ff.track_id);
         end
         STEP_PR_KEY: begin
            ev_type = EVT_KEY;
            ev_code = CODE_BTN_TOUCH;
            ev_value = VALUE_ONE;
         end
         STEP_MV_X: begin
            ev_type = EVT_ABS;
            ev_code = cur_ff.multi ? CODE_MT_X : CODE_ABS_X;
            ev_value = cur_ff.pos_x;
         end
         STEP_MV_Y: begin
            ev_type = EVT_ABS;
            ev_code = cur_ff.multi ? CODE_MT_Y : CODE_ABS_Y;
            ev_value = cur_ff.pos_y;
         end
         STEP_MV_PRESS: begin
            ev_type = EVT_ABS;
            ev_code = CODE_MT_PRESS;
            ev_value = VALUE_PRESSURE;
         end
         default: begin
            ev_type = EVT_SYN;
            ev_code = CODE_SYN_REPORT;
            ev_value = VALUE_ZERO;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff.steps <= STEP_NONE;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            cur_ff <= q_cmd;
         end else if (emit) begin
            cur_ff.steps <= rest;
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_type_ff <= ev_type;
         out_code_ff <= ev_code;
         out_value_ff <= ev_value;
         out_last_ff <= rest == STEP_NONE;
      end
   end

   assign out_valid = out_valid_ff;
   assign event_type = out_type_ff;
   assign event_code = out_code_ff;
   assign event_value = out_value_ff;
   assign last_event = out_last_ff;

   ap_entry_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |=> have)
      else $error("queued command carries no events");

   ap_last_is_sync: assert property (@(posedge clock) disable iff (reset)
      (emit && rest == STEP_NONE) |-> ev_type == EVT_SYN)
      else $error("sequence does not end in a sync report");

endmodule
